### rtl/core/rmsm_pkg.sv
// Shared types and constants for the running mean / deviation / min-max block.
`timescale 1ns / 1ps

package rmsm_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int COUNT_W   = 17;
	localparam int MEAN_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int SUM_W     = 64;
	localparam int MAG_W     = 32;
	localparam int ROOT_W    = 32;
	localparam int SD_W      = 24;
	localparam int ACT_W     = 2;
	localparam int STEP_W    = 7;

	localparam logic [COUNT_W-1:0]  MAX_SAMPLES = COUNT_W'(65536);
	localparam logic [SAMPLE_W-1:0] MIN_INIT    = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic [SAMPLE_W-1:0] MAX_INIT    = {1'b1, {(SAMPLE_W-1){1'b0}}};

	localparam logic [STEP_W-1:0] DIV_STEPS_NARROW = STEP_W'(MAG_W);
	localparam logic [STEP_W-1:0] DIV_STEPS_WIDE   = STEP_W'(SUM_W);
	localparam logic [STEP_W-1:0] SQRT_STEPS       = STEP_W'(ROOT_W);

	// Action codes of an input request
	localparam logic [ACT_W-1:0] ACT_ADD     = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ADD_FIN = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FIN     = 2'd2;

	// Controller states, one-hot
	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_ADD  = 10'b00_0000_0010,
		ST_DIVM = 10'b00_0000_0100,
		ST_MEAN = 10'b00_0000_1000,
		ST_MUL  = 10'b00_0001_0000,
		ST_ACC  = 10'b00_0010_0000,
		ST_FIN  = 10'b00_0100_0000,
		ST_DIVV = 10'b00_1000_0000,
		ST_SQRT = 10'b01_0000_0000,
		ST_EMIT = 10'b10_0000_0000
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;       // capture input request
		logic add_first;  // first sample of a set
		logic add_next;   // later sample: take deviation, start divider
		logic set_ovf;    // sample dropped for capacity
		logic upd_mean;   // apply quotient to mean
		logic mul;        // deviation product
		logic acc;        // accumulate product
		logic var_start;  // start S / n
		logic sqrt_start; // start square root
		logic take_sd;    // capture root
		logic zero_sd;    // empty set
		logic emit;       // load output register, clear set
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic             full;
		logic             empty;
		logic             div_done;
		logic             sqrt_done;
		logic             out_free;
	} stat_t;

endpackage

### rtl/core/rmsm_div.sv
// Iterative restoring divider, one quotient bit per cycle, 32 or 64 steps.
`timescale 1ns / 1ps

module rmsm_div
	import rmsm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               wide,
	input  logic [SUM_W-1:0]   dividend,
	input  logic [COUNT_W-1:0] divisor,
	output logic [SUM_W-1:0]   quotient,
	output logic               done
);

	logic [SUM_W-1:0]   dvd_q;
	logic [COUNT_W-1:0] den_q;
	logic [COUNT_W-1:0] rem_q;
	logic [STEP_W-1:0]  cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [COUNT_W:0]   rem_sh;
	logic [COUNT_W:0]   rem_sub;
	logic               qbit;

	// One shift-subtract step
	always_comb begin
		rem_sh  = {rem_q, dvd_q[SUM_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		qbit    = (rem_sh >= {1'b0, den_q});
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= wide ? DIV_STEPS_WIDE : DIV_STEPS_NARROW;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operands; a narrow request is aligned to the top of the shifter
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= wide ? dividend : {dividend[MAG_W-1:0], {(SUM_W-MAG_W){1'b0}}};
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SUM_W-2:0], qbit};
			rem_q <= qbit ? rem_sub[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
		end
	end

	assign quotient = dvd_q;
	assign done     = done_q;

endmodule

### rtl/core/rmsm_sqrt.sv
// Iterative integer square root, one root bit per cycle.
`timescale 1ns / 1ps

module rmsm_sqrt
	import rmsm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SUM_W-1:0]  radicand,
	output logic [ROOT_W-1:0] root,
	output logic              done
);

	logic [SUM_W-1:0]    rad_q;
	logic [ROOT_W:0]     rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [STEP_W-1:0]   cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [ROOT_W+2:0]   rem_sh;
	logic [ROOT_W+2:0]   trial;
	logic [ROOT_W+2:0]   rem_sub;
	logic                fit;

	// Bring down two radicand bits, try root*4+1
	always_comb begin
		rem_sh  = {rem_q, rad_q[SUM_W-1:SUM_W-2]};
		trial   = {1'b0, root_q, 2'b01};
		rem_sub = rem_sh - trial;
		fit     = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SQRT_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SUM_W-3:0], 2'b00};
			rem_q  <= fit ? rem_sub[ROOT_W:0] : rem_sh[ROOT_W:0];
			root_q <= {root_q[ROOT_W-2:0], fit};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

### rtl/core/rmsm_ctrl.sv
// Sequencing state machine for sample update and set finish.
`timescale 1ns / 1ps

module rmsm_ctrl
	import rmsm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;
	logic   fin_after;

	assign fin_after = (stat.act == ACT_ADD_FIN);
	assign in_ready  = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_ADD;
				end
			end
			ST_ADD: begin
				priority case (stat.act)
					ACT_ADD, ACT_ADD_FIN: begin
						if (stat.full) begin
							cmd.set_ovf = 1'b1;
							state_d     = fin_after ? ST_FIN : ST_IDLE;
						end else if (stat.empty) begin
							cmd.add_first = 1'b1;
							state_d       = fin_after ? ST_FIN : ST_IDLE;
						end else begin
							cmd.add_next = 1'b1;
							state_d      = ST_DIVM;
						end
					end
					ACT_FIN: state_d = ST_FIN;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_DIVM: begin
				if (stat.div_done) begin
					state_d = ST_MEAN;
				end
			end
			ST_MEAN: begin
				cmd.upd_mean = 1'b1;
				state_d      = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = fin_after ? ST_FIN : ST_IDLE;
			end
			ST_FIN: begin
				if (stat.empty) begin
					cmd.zero_sd = 1'b1;
					state_d     = ST_EMIT;
				end else begin
					cmd.var_start = 1'b1;
					state_d       = ST_DIVV;
				end
			end
			ST_DIVV: begin
				if (stat.div_done) begin
					cmd.sqrt_start = 1'b1;
					state_d        = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (stat.sqrt_done) begin
					cmd.take_sd = 1'b1;
					state_d     = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/core/rmsm_dp.sv
// Datapath: set state, Welford update arithmetic and result register.
`timescale 1ns / 1ps

module rmsm_dp
	import rmsm_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmd_t                       cmd,
	output stat_t                      stat,
	input  logic [ACT_W-1:0]           action,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] min_value,
	output logic signed [SAMPLE_W-1:0] max_value,
	output logic signed [MEAN_W-1:0]   mean_value,
	output logic [SD_W-1:0]            std_dev,
	output logic [COUNT_W-1:0]         sample_count,
	output logic                       overflow
);

	// Captured request
	logic [ACT_W-1:0]           act_q;
	logic signed [SAMPLE_W-1:0] smp_q;

	// Set state
	logic [COUNT_W-1:0]         count_q;
	logic [MEAN_W-1:0]          mean_q;
	logic [SUM_W-1:0]           sum_q;
	logic signed [SAMPLE_W-1:0] min_q;
	logic signed [SAMPLE_W-1:0] max_q;
	logic                       ovf_q;

	// Working registers
	logic [MAG_W-1:0]  dmag_q;
	logic              dneg_q;
	logic [MAG_W-1:0]  emag_q;
	logic              eneg_q;
	logic [SUM_W-1:0]  prod_q;
	logic [SD_W-1:0]   sd_q;
	logic              out_valid_q;

	// Arithmetic
	logic [MEAN_W-1:0] x_w;
	logic [MEAN_W:0]   d_w;
	logic [MEAN_W:0]   dabs_w;
	logic [MEAN_W:0]   qx_w;
	logic [MEAN_W:0]   m_w;
	logic [MEAN_W:0]   e_w;
	logic [MEAN_W:0]   eabs_w;
	logic [SUM_W:0]    sum_w;
	logic [SUM_W-FRAC_W-1:0] p_w;

	// Shared units
	logic              div_start;
	logic [SUM_W-1:0]  div_dvd;
	logic [COUNT_W-1:0] div_den;
	logic [SUM_W-1:0]  div_quot;
	logic              div_done;
	logic [ROOT_W-1:0] sqrt_root;
	logic              sqrt_done;

	// Deviation from old mean, then new mean and second deviation
	always_comb begin
		x_w    = {smp_q, {FRAC_W{1'b0}}};
		d_w    = {x_w[MEAN_W-1], x_w} - {mean_q[MEAN_W-1], mean_q};
		dabs_w = d_w[MEAN_W] ? ((MEAN_W+1)'(0) - d_w) : d_w;
		qx_w   = dneg_q ? ((MEAN_W+1)'(0) - {1'b0, div_quot[MAG_W-1:0]})
		                : {1'b0, div_quot[MAG_W-1:0]};
		m_w    = {mean_q[MEAN_W-1], mean_q} + qx_w;
		e_w    = {x_w[MEAN_W-1], x_w} - {m_w[MEAN_W-1], m_w[MEAN_W-1:0]};
		eabs_w = e_w[MEAN_W] ? ((MEAN_W+1)'(0) - e_w) : e_w;
		p_w    = prod_q[SUM_W-1:FRAC_W];
		sum_w  = {1'b0, sum_q} + {{(FRAC_W+1){1'b0}}, p_w};
	end

	// Divider: mean step on |d| / (n+1), finish step on S / n
	assign div_start = cmd.add_next | cmd.var_start;
	assign div_dvd   = cmd.var_start ? sum_q : {{(SUM_W-MAG_W){1'b0}}, dabs_w[MAG_W-1:0]};
	assign div_den   = cmd.var_start ? count_q : (count_q + COUNT_W'(1));

	rmsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.wide     (cmd.var_start),
		.dividend (div_dvd),
		.divisor  (div_den),
		.quotient (div_quot),
		.done     (div_done)
	);

	rmsm_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (div_quot),
		.root     (sqrt_root),
		.done     (sqrt_done)
	);

	// Request capture and working values
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			smp_q <= sample;
		end
		if (cmd.add_next) begin
			dmag_q <= dabs_w[MAG_W-1:0];
			dneg_q <= d_w[MEAN_W];
		end
		if (cmd.upd_mean) begin
			emag_q <= eabs_w[MAG_W-1:0];
			eneg_q <= e_w[MEAN_W];
		end
		// Opposite signs give a negative product, clamped to zero
		if (cmd.mul) begin
			prod_q <= (dneg_q != eneg_q) ? '0 : (SUM_W'(dmag_q) * SUM_W'(emag_q));
		end
		if (cmd.take_sd) begin
			sd_q <= sqrt_root[SD_W-1:0];
		end else if (cmd.zero_sd) begin
			sd_q <= '0;
		end
	end

	// Set state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mean_q  <= '0;
			sum_q   <= '0;
			min_q   <= MIN_INIT;
			max_q   <= MAX_INIT;
			ovf_q   <= 1'b0;
		end else if (cmd.emit) begin
			count_q <= '0;
			mean_q  <= '0;
			sum_q   <= '0;
			min_q   <= MIN_INIT;
			max_q   <= MAX_INIT;
			ovf_q   <= 1'b0;
		end else begin
			if (cmd.add_first || cmd.add_next) begin
				count_q <= count_q + COUNT_W'(1);
				if (smp_q < min_q) begin
					min_q <= smp_q;
				end
				if (smp_q > max_q) begin
					max_q <= smp_q;
				end
			end
			if (cmd.add_first) begin
				mean_q <= x_w;
				sum_q  <= '0;
			end
			if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (cmd.upd_mean) begin
				mean_q <= m_w[MEAN_W-1:0];
			end
			// Saturating accumulate
			if (cmd.acc) begin
				sum_q <= sum_w[SUM_W] ? '1 : sum_w[SUM_W-1:0];
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			min_value    <= min_q;
			max_value    <= max_q;
			mean_value   <= (count_q != '0) ? mean_q : '0;
			std_dev      <= sd_q;
			sample_count <= count_q;
			overflow     <= ovf_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign stat.act       = act_q;
	assign stat.full      = (count_q == MAX_SAMPLES);
	assign stat.empty     = (count_q == '0);
	assign stat.div_done  = div_done;
	assign stat.sqrt_done = sqrt_done;
	assign stat.out_free  = !out_valid_q || out_ready;

endmodule

### rtl/core/running_mean_stddev_minmax_top.sv
// Running count, min, max, mean and standard deviation unit: top level.
//
// Input channel (in_valid/in_ready, action, sample): each request adds a
// signed sample, adds a sample and then finishes the set, or finishes the
// set alone. Output channel (out_valid/out_ready): one result per finish,
// with min, max, Q16.16 mean, Q16.8 population deviation, count, overflow.
// One request is worked at a time; in_ready is high only when idle.
// Add sample: in_ready stays low through the 32-step serial divider (|d| / n)
// and the mean, product and accumulate steps before it rises again.
// First sample of a set, or a dropped one: in_ready returns after the ADD state.
// Finish: out_valid follows a 64-step divide of S by n, then a 32-step square
// root, after the add steps if any; an empty set skips both and goes to emit.
// The result register holds one finished set; the next set is taken in
// while it waits. A later finish waits in place until the receiver takes
// the pending result, so nothing is dropped when out_ready is low.
// Reset clears the set (count 0, min 32767, max -32768) and the output
// valid; no clearing pass is needed.
`timescale 1ns / 1ps

module running_mean_stddev_minmax_top
	import rmsm_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [ACT_W-1:0]           action,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] min_value,
	output logic signed [SAMPLE_W-1:0] max_value,
	output logic signed [MEAN_W-1:0]   mean_value,
	output logic [SD_W-1:0]            std_dev,
	output logic [COUNT_W-1:0]         sample_count,
	output logic                       overflow
);

	cmd_t  cmd;
	stat_t stat;

	rmsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rmsm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.action       (action),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.min_value    (min_value),
		.max_value    (max_value),
		.mean_value   (mean_value),
		.std_dev      (std_dev),
		.sample_count (sample_count),
		.overflow     (overflow)
	);

`ifndef SYNTHESIS
	// A pending result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid || out_ready))
		else $error("result register overwritten while pending");

	// Divider completes only while a request is in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> !in_ready)
		else $error("divider done while idle");

	// Overflow is only reported with a full count
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && overflow) |-> (sample_count == MAX_SAMPLES))
		else $error("overflow without full count");

	// Count never passes capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sample_count <= MAX_SAMPLES))
		else $error("sample count beyond capacity");
`endif

endmodule

### tb/tb.sv
// Self-checking testbench for the running mean / deviation / min-max unit.
`timescale 1ns / 1ps

module tb;
	import rmsm_pkg::*;

	// Action code the block must ignore
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam int N_DIRECTED = 24;
	localparam int RANDOM_ITEMS = 500;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] min_v;
		logic signed [SAMPLE_W-1:0] max_v;
		logic signed [MEAN_W-1:0]   mean;
		logic [SD_W-1:0]            sd;
		logic [COUNT_W-1:0]         cnt;
		logic                       ovf;
	} set_summary_t;

	typedef struct packed {
		logic [ACT_W-1:0]           act;
		logic signed [SAMPLE_W-1:0] smp;
		logic                       fixed_exp;
		set_summary_t               want;
	} req_row_t;

	localparam set_summary_t EMPTY_SET = '{MIN_INIT, MAX_INIT, 32'd0, 24'd0, 17'd0, 1'b0};
	localparam set_summary_t NO_RESULT = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [ACT_W-1:0] action = '0;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] min_value;
	logic signed [SAMPLE_W-1:0] max_value;
	logic signed [MEAN_W-1:0] mean_value;
	logic [SD_W-1:0] std_dev;
	logic [COUNT_W-1:0] sample_count;
	logic overflow;

	running_mean_stddev_minmax_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.min_value(min_value),
		.max_value(max_value),
		.mean_value(mean_value),
		.std_dev(std_dev),
		.sample_count(sample_count),
		.overflow(overflow)
	);

	always #6 clk = ~clk;

	// Set summaries still owed by the block, oldest first
	set_summary_t pending_sets[$];
	int errors = 0;
	bit no_idle = 1'b0;

	// Directed requests; summaries typed in only where obvious
	req_row_t directed_rows [N_DIRECTED] = '{
		'{ACT_FIN,     16'h0000, 1'b1, EMPTY_SET},
		'{ACT_ADD_FIN, 16'h7FFF, 1'b1, '{16'h7FFF, 16'h7FFF, 32'h7FFF_0000, 24'd0, 17'd1, 1'b0}},
		'{ACT_ADD_FIN, 16'h8000, 1'b1, '{16'h8000, 16'h8000, 32'h8000_0000, 24'd0, 17'd1, 1'b0}},
		'{ACT_UNUSED,  16'h5A5A, 1'b0, NO_RESULT},
		'{ACT_ADD,     16'h0000, 1'b0, NO_RESULT},
		'{ACT_ADD,     16'h0000, 1'b0, NO_RESULT},
		'{ACT_ADD_FIN, 16'h0000, 1'b1, '{16'h0000, 16'h0000, 32'd0, 24'd0, 17'd3, 1'b0}},
		'{ACT_ADD,     16'h8000, 1'b0, NO_RESULT},
		'{ACT_UNUSED,  16'hFFFF, 1'b0, NO_RESULT},
		'{ACT_ADD,     16'h7FFF, 1'b0, NO_RESULT},
		'{ACT_ADD,     16'h8000, 1'b0, NO_RESULT},
		'{ACT_ADD_FIN, 16'h7FFF, 1'b0, NO_RESULT},
		'{ACT_FIN,     16'h1234, 1'b1, EMPTY_SET},
		'{ACT_ADD,     16'h0000, 1'b0, NO_RESULT},
		'{ACT_ADD,     16'h0000, 1'b0, NO_RESULT},
		'{ACT_ADD,     16'hFFFF, 1'b0, NO_RESULT},
		'{ACT_ADD_FIN, 16'h0001, 1'b0, NO_RESULT},
		'{ACT_ADD,     16'h5555, 1'b0, NO_RESULT},
		'{ACT_ADD,     16'hAAAA, 1'b0, NO_RESULT},
		'{ACT_ADD,     16'hFFFF, 1'b0, NO_RESULT},
		'{ACT_ADD,     16'h0007, 1'b0, NO_RESULT},
		'{ACT_FIN,     16'hFFFF, 1'b0, NO_RESULT},
		'{ACT_ADD,     16'h0005, 1'b0, NO_RESULT},
		'{ACT_ADD_FIN, 16'h0005, 1'b1, '{16'h0005, 16'h0005, 32'h0005_0000, 24'd0, 17'd2, 1'b0}}
	};

	// Running statistics of the open set
	logic [COUNT_W-1:0] acc_count;
	longint acc_mean;
	logic [63:0] acc_sq;
	logic signed [SAMPLE_W-1:0] acc_min;
	logic signed [SAMPLE_W-1:0] acc_max;
	bit acc_ovf;

	function automatic logic [63:0] root_floor(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	task automatic clear_set();
		acc_count = '0;
		acc_mean = 0;
		acc_sq = '0;
		acc_min = MIN_INIT;
		acc_max = MAX_INIT;
		acc_ovf = 1'b0;
	endtask

	// Welford update with the mean in Q16.16 and S in 2^-16 units
	task automatic take_sample(input logic signed [SAMPLE_W-1:0] s);
		longint x;
		longint d;
		longint e;
		longint m;
		logic [63:0] md;
		logic [63:0] me;
		logic [63:0] p;
		logic [127:0] prod;
		if (acc_count >= MAX_SAMPLES) begin
			acc_ovf = 1'b1;
			return;
		end
		if (s > acc_max)
			acc_max = s;
		if (s < acc_min)
			acc_min = s;
		x = longint'(s) * 65536;
		acc_count = acc_count + COUNT_W'(1);
		if (acc_count == 1) begin
			acc_mean = x;
			acc_sq = '0;
			return;
		end
		d = x - acc_mean;
		m = acc_mean + d / longint'(acc_count);
		e = x - m;
		acc_mean = m;
		// deviations of opposite sign contribute nothing
		if (d == 0 || e == 0 || ((d < 0) != (e < 0))) begin
			p = '0;
		end else begin
			md = (d < 0) ? -d : d;
			me = (e < 0) ? -e : e;
			prod = {64'd0, md} * {64'd0, me};
			p = (prod[127:112] != 0) ? '1 : prod[79:16];
		end
		acc_sq = (acc_sq > ~p) ? '1 : acc_sq + p;
	endtask

	task automatic welford_step(input logic [ACT_W-1:0] a, input logic signed [SAMPLE_W-1:0] s,
			output bit emits, output set_summary_t r);
		emits = 1'b0;
		r = NO_RESULT;
		if (a == ACT_ADD || a == ACT_ADD_FIN)
			take_sample(s);
		if (a == ACT_ADD_FIN || a == ACT_FIN) begin
			emits = 1'b1;
			r.min_v = acc_min;
			r.max_v = acc_max;
			r.mean = (acc_count != 0) ? 32'(acc_mean) : 32'd0;
			r.sd = (acc_count != 0) ? 24'(root_floor(acc_sq / 64'(acc_count))) : 24'd0;
			r.cnt = acc_count;
			r.ovf = acc_ovf;
			clear_set();
		end
	endtask

	// Mostly short gaps, a few long enough to span a whole finish
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(20, 120);
	endfunction

	task automatic idle_gap();
		int gap;
		gap = no_idle ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold the request until accepted, then predict its summary
	task automatic push_request(input logic [ACT_W-1:0] a, input logic signed [SAMPLE_W-1:0] s,
			input logic fixed_exp, input set_summary_t want);
		bit emits;
		set_summary_t pred;
		in_valid <= 1'b1;
		action <= a;
		sample <= s;
		do @(posedge clk); while (!in_ready);
		welford_step(a, s, emits, pred);
		if (emits)
			pending_sets.push_back(fixed_exp ? want : pred);
	endtask

	task automatic drain_sets();
		in_valid <= 1'b0;
		while (pending_sets.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample(
			input logic signed [SAMPLE_W-1:0] base);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
		if (r <= 3)
			return base + SAMPLE_W'($urandom_range(0, 30)) - 16'sd15;
		return SAMPLE_W'($urandom);
	endfunction

	// Receiver: random stalls of random length
	int rx_hold = 0;
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
		end else begin
			out_ready <= ($urandom_range(0, 3) != 0);
			rx_hold = idle_len();
		end
	end

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t %s: expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Compare each taken summary with the oldest one owed
	always @(posedge clk) begin
		set_summary_t exp_set;
		if (arst_n && out_valid && out_ready) begin
			if (pending_sets.size() == 0) begin
				$display("%0t unexpected summary: min %0d max %0d mean %0d sd %0d count %0d",
					$time, min_value, max_value, mean_value, std_dev, sample_count);
				errors++;
			end else begin
				exp_set = pending_sets.pop_front();
				check_field("min_value", exp_set.min_v, min_value);
				check_field("max_value", exp_set.max_v, max_value);
				check_field("mean_value", exp_set.mean, mean_value);
				check_field("std_dev", exp_set.sd, std_dev);
				check_field("sample_count", exp_set.cnt, sample_count);
				check_field("overflow", exp_set.ovf, overflow);
			end
		end
	end

	initial begin
		#120_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int sent;
		int len;
		bit close_alone;
		bit paused;
		logic [ACT_W-1:0] act;
		logic signed [SAMPLE_W-1:0] base;
		sent = 0;
		paused = 1'b0;
		clear_set();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests
		for (int i = 0; i < N_DIRECTED; i++) begin
			idle_gap();
			push_request(directed_rows[i].act, directed_rows[i].smp,
				directed_rows[i].fixed_exp, directed_rows[i].want);
		end

		// Random sets, mostly short, with ignored requests mixed in
		while (sent < RANDOM_ITEMS) begin
			no_idle = ($urandom_range(0, 4) == 0);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
			base = SAMPLE_W'($urandom);
			close_alone = (len == 0) || ($urandom_range(0, 2) == 0);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 19) == 0) begin
					idle_gap();
					push_request(ACT_UNUSED, SAMPLE_W'($urandom), 1'b0, NO_RESULT);
				end
				act = (i == len - 1 && !close_alone) ? ACT_ADD_FIN : ACT_ADD;
				idle_gap();
				push_request(act, pick_sample(base), 1'b0, NO_RESULT);
				sent++;
			end
			if (close_alone) begin
				idle_gap();
				push_request(ACT_FIN, SAMPLE_W'($urandom), 1'b0, NO_RESULT);
				sent++;
			end
			// hold off once until every owed summary is out
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				drain_sets();
				paused = 1'b1;
			end
		end

		drain_sets();
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
